/* rtl/strx_pkg.sv */
// Shared types, constants and CRC step for the scan telegram receiver.
package strx_pkg;

  localparam int unsigned POS_W = 11;

  // Fixed byte positions inside a telegram
  localparam logic [POS_W-1:0] POS_SYNC_LAST   = 11'd2;
  localparam logic [POS_W-1:0] POS_ERROR       = 11'd3;
  localparam logic [POS_W-1:0] POS_LEN_HI      = 11'd6;
  localparam logic [POS_W-1:0] POS_LEN_LO      = 11'd7;
  localparam logic [POS_W-1:0] POS_LEN_CHECK   = 11'd9;
  localparam logic [POS_W-1:0] POS_VER_LO      = 11'd10;
  localparam logic [POS_W-1:0] POS_VER_HI      = 11'd11;
  localparam logic [POS_W-1:0] POS_STAT_0      = 11'd12;
  localparam logic [POS_W-1:0] POS_STAT_1      = 11'd13;
  localparam logic [POS_W-1:0] POS_SCAN_0      = 11'd14;
  localparam logic [POS_W-1:0] POS_SCAN_1      = 11'd15;
  localparam logic [POS_W-1:0] POS_SCAN_2      = 11'd16;
  localparam logic [POS_W-1:0] POS_SCAN_3      = 11'd17;
  localparam logic [POS_W-1:0] POS_TELE_LO     = 11'd18;
  localparam logic [POS_W-1:0] POS_TELE_HI     = 11'd19;
  localparam logic [POS_W-1:0] POS_CHECK       = 11'd1103;
  localparam logic [POS_W-1:0] POS_PAYLOAD_END = 11'd1105;
  localparam logic [POS_W-1:0] POS_CRC_LO      = 11'd1106;
  localparam logic [POS_W-1:0] POS_LAST        = 11'd1107;

  localparam logic [15:0] LEN_RESET = 16'd552;
  localparam logic [15:0] VER_RESET = 16'd258;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  // Configuration register indexes
  localparam logic CFG_LENGTH  = 1'b0;
  localparam logic CFG_VERSION = 1'b1;

  // Single-bit flag codes mark a measurement as invalid
  localparam logic [2:0] FLAG_WARN  = 3'd4;
  localparam logic [2:0] FLAG_PROT  = 3'd2;
  localparam logic [2:0] FLAG_GLARE = 3'd1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DEVICE  = 3'd1,
    ST_LENGTH  = 3'd2,
    ST_VERSION = 3'd3,
    ST_STATUS  = 3'd4,
    ST_CRC     = 3'd5
  } strx_status_e;

  typedef struct packed {
    logic         kind;
    logic [9:0]   meas_index;
    logic [12:0]  distance_cm;
    logic [2:0]   field_flags;
    logic         meas_valid;
    strx_status_e frame_status;
    logic [7:0]   device_error_code;
    logic [31:0]  scan_number;
    logic [15:0]  telegram_number;
  } strx_result_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic strx_result_t make_report(input strx_status_e status,
                                               input logic [7:0] code,
                                               input logic [31:0] scan,
                                               input logic [15:0] tele);
    strx_result_t r;
    r = '0;
    r.kind              = 1'b1;
    r.frame_status      = status;
    r.device_error_code = code;
    r.scan_number       = scan;
    r.telegram_number   = tele;
    return r;
  endfunction

endpackage

/* rtl/scan_telegram_receiver_top.sv */
// Top level of the scan telegram receiver: parser plus registered result stage.
//
// Input channel: one telegram byte per transfer on rx_byte_i (in_valid_i / in_stall_o).
// Output channel: one result per transfer, either a measurement (kind_o = 0) or an
// end-of-telegram / error report (kind_o = 1) carrying frame_status_o.
// Configuration: cfg_we_i writes cfg_wdata_i to the register at cfg_idx_i
// (0 expected length word, 1 expected version); write only while idle.
// Throughput: one byte per cycle while in_stall_o is low; all parsing and the CRC
// byte step sit between the parser state registers and the result register.
// Results: each is registered in the result register, or in the skid entry on stall.
// Stall: the result register is backed by one skid entry; in_stall_o rises only
// once both hold a result, so the input keeps flowing under stall until the skid fills.
// Reset: the parser hunts for sync, the CRC is preset to all ones, both config
// registers take their defaults and no result is pending.
// Consumers drop the measurements of a frame whose final report is not ok.
module scan_telegram_receiver_top #(
  parameter int unsigned MEAS_COUNT  = 541,
  parameter int unsigned MEAS_OFFSET = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [9:0]  meas_index_o,
  output logic [12:0] distance_cm_o,
  output logic [2:0]  field_flags_o,
  output logic        meas_valid_o,
  output logic [2:0]  frame_status_o,
  output logic [7:0]  device_error_code_o,
  output logic [31:0] scan_number_o,
  output logic [15:0] telegram_number_o
);

  logic                   accept;
  logic                   res_valid;
  logic                   full;
  strx_pkg::strx_result_t res, out;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  strx_parser #(
    .MEAS_COUNT  (MEAS_COUNT),
    .MEAS_OFFSET (MEAS_OFFSET)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  strx_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out)
  );

  assign kind_o              = out.kind;
  assign meas_index_o        = out.meas_index;
  assign distance_cm_o       = out.distance_cm;
  assign field_flags_o       = out.field_flags;
  assign meas_valid_o        = out.meas_valid;
  assign frame_status_o      = 3'(out.frame_status);
  assign device_error_code_o = out.device_error_code;
  assign scan_number_o       = out.scan_number;
  assign telegram_number_o   = out.telegram_number;

endmodule

/* rtl/strx_parser.sv */
// Telegram byte parser: position tracking, header checks, CRC and measurement decode.
module strx_parser #(
  parameter int unsigned MEAS_COUNT  = 541,
  parameter int unsigned MEAS_OFFSET = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  res_valid_o,
  output strx_pkg::strx_result_t res_o
);

  logic [15:0]                  exp_len_q, exp_ver_q;
  logic [strx_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [15:0]                  crc_q, crc_d;
  logic [7:0]                   held_q, held_d;
  logic [15:0]                  ver_q, ver_d;
  logic                         stat_q, stat_d;
  logic [31:0]                  scan_q, scan_d;
  logic [15:0]                  tele_q, tele_d;
  logic [strx_pkg::POS_W-1:0]   off;
  logic [9:0]                   idx;
  logic [2:0]                   flags;
  logic                         done;
  logic [7:0]                   b;

  assign b     = rx_byte_i;
  assign off   = pos_q - strx_pkg::POS_W'(MEAS_OFFSET);
  assign idx   = off[strx_pkg::POS_W-1:1];
  assign flags = b[7:5];

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    held_d      = held_q;
    ver_d       = ver_q;
    stat_d      = stat_q;
    scan_d      = scan_q;
    tele_d      = tele_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    done        = 1'b0;
    if (accept_i) begin
      if (pos_q <= strx_pkg::POS_SYNC_LAST) begin
        pos_d = (b == 8'h00) ? pos_q + 1'b1 : '0;
      end else if (pos_q == strx_pkg::POS_ERROR) begin
        // Start of a new frame
        crc_d  = strx_pkg::CRC_INIT;
        stat_d = 1'b0;
        scan_d = '0;
        tele_d = '0;
        ver_d  = '0;
        if (b != 8'h00) begin
          res_valid_o = 1'b1;
          res_o       = strx_pkg::make_report(strx_pkg::ST_DEVICE, b, '0, '0);
          pos_d       = '0;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end else begin
        if (pos_q <= strx_pkg::POS_PAYLOAD_END) begin
          crc_d = strx_pkg::crc16_step(crc_q, b);
        end
        if (pos_q == strx_pkg::POS_LEN_HI) begin
          held_d = b;
        end else if (pos_q == strx_pkg::POS_LEN_LO) begin
          ver_d = {held_q, b};
        end else if (pos_q == strx_pkg::POS_LEN_CHECK) begin
          if (ver_q != exp_len_q) begin
            res_valid_o = 1'b1;
            res_o       = strx_pkg::make_report(strx_pkg::ST_LENGTH, '0, scan_q, tele_q);
            done        = 1'b1;
          end
        end else if (pos_q == strx_pkg::POS_VER_LO) begin
          held_d = b;
        end else if (pos_q == strx_pkg::POS_VER_HI) begin
          ver_d = {b, held_q};
        end else if (pos_q == strx_pkg::POS_STAT_0 || pos_q == strx_pkg::POS_STAT_1) begin
          if (b != 8'h00) begin
            stat_d = 1'b1;
          end
        end else if (pos_q == strx_pkg::POS_SCAN_0) begin
          scan_d[7:0] = b;
        end else if (pos_q == strx_pkg::POS_SCAN_1) begin
          scan_d[15:8] = b;
        end else if (pos_q == strx_pkg::POS_SCAN_2) begin
          scan_d[23:16] = b;
        end else if (pos_q == strx_pkg::POS_SCAN_3) begin
          scan_d[31:24] = b;
        end else if (pos_q == strx_pkg::POS_TELE_LO) begin
          tele_d = {8'h00, b};
        end else if (pos_q == strx_pkg::POS_TELE_HI) begin
          tele_d[15:8] = b;
        end else if (pos_q == strx_pkg::POS_CRC_LO) begin
          held_d = b;
        end else if (pos_q >= strx_pkg::POS_LAST) begin
          res_valid_o = 1'b1;
          res_o = strx_pkg::make_report(({b, held_q} == crc_q) ? strx_pkg::ST_OK
                                                               : strx_pkg::ST_CRC,
                                        '0, scan_q, tele_q);
          done  = 1'b1;
        end

        if (!done && pos_q == strx_pkg::POS_CHECK) begin
          if (ver_q != exp_ver_q) begin
            res_valid_o = 1'b1;
            res_o       = strx_pkg::make_report(strx_pkg::ST_VERSION, '0, scan_q, tele_q);
            done        = 1'b1;
          end else if (stat_q) begin
            res_valid_o = 1'b1;
            res_o       = strx_pkg::make_report(strx_pkg::ST_STATUS, '0, scan_q, tele_q);
            done        = 1'b1;
          end
        end

        if (done) begin
          pos_d = '0;
        end else begin
          pos_d = pos_q + 1'b1;
          if (pos_q >= strx_pkg::POS_W'(MEAS_OFFSET) && pos_q <= strx_pkg::POS_PAYLOAD_END &&
              {1'b0, idx} < strx_pkg::POS_W'(MEAS_COUNT)) begin
            if (!off[0]) begin
              held_d = b;
            end else begin
              res_valid_o             = 1'b1;
              res_o.kind              = 1'b0;
              res_o.meas_index        = idx;
              res_o.distance_cm       = {b[4:0], held_q};
              res_o.field_flags       = flags;
              res_o.meas_valid        = !(flags == strx_pkg::FLAG_WARN ||
                                          flags == strx_pkg::FLAG_PROT ||
                                          flags == strx_pkg::FLAG_GLARE);
              res_o.frame_status      = strx_pkg::ST_OK;
              res_o.device_error_code = '0;
              res_o.scan_number       = scan_q;
              res_o.telegram_number   = tele_q;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= strx_pkg::LEN_RESET;
      exp_ver_q <= strx_pkg::VER_RESET;
      pos_q     <= '0;
      crc_q     <= strx_pkg::CRC_INIT;
      held_q    <= '0;
      ver_q     <= '0;
      stat_q    <= 1'b0;
      scan_q    <= '0;
      tele_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == strx_pkg::CFG_LENGTH) begin
          exp_len_q <= cfg_wdata_i;
        end else begin
          exp_ver_q <= cfg_wdata_i;
        end
      end
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      held_q <= held_d;
      ver_q  <= ver_d;
      stat_q <= stat_d;
      scan_q <= scan_d;
      tele_q <= tele_d;
    end
  end

endmodule

/* rtl/strx_skid.sv */
// Result register with one skid entry so the parser keeps running under output stall.
module strx_skid (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_valid_i,
  input  strx_pkg::strx_result_t res_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output strx_pkg::strx_result_t out_o
);

  logic                   out_valid_q, skid_valid_q;
  strx_pkg::strx_result_t out_q, skid_q;
  logic                   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // Input is held off while the skid entry is occupied
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_q <= res_valid_i;
    end else if (res_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      out_q <= res_i;
    end else begin
      skid_q <= res_i;
    end
  end

endmodule
